[hw/rtl/bnss_pkg.sv]
// ----------------------------------------------------------------------------
// bnss_pkg
// Shared widths, reset values and types for the bitmap nth-set-bit selector.
// ----------------------------------------------------------------------------
package bnss_pkg;

	localparam int WORD_W = 64;  // bits in one bitmap word
	localparam int SEL_W  = 4;   // word index carried by a write request
	localparam int WIDX_W = 5;   // word index as searched (up to 31 words)
	localparam int POS_W  = 11;  // bit position
	localparam int RANK_W = 10;  // rank of the wanted set bit
	localparam int CFG_W  = 5;   // words_in_use register

	localparam logic [CFG_W-1:0] WORDS_IN_USE_RESET = 5'd16;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// Write port of the bitmap store.
	typedef struct packed {
		logic             en;
		logic [SEL_W-1:0] addr;
		word_t            data;
	} store_wr_t;

endpackage

[hw/rtl/bnss_req_if.sv]
// ----------------------------------------------------------------------------
// bnss_req_if
// Request channel: bitmap word writes and nth-set-bit queries.
// ----------------------------------------------------------------------------
interface bnss_req_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [bnss_pkg::SEL_W-1:0]  word_select;
	logic [bnss_pkg::WORD_W-1:0] word_value;
	logic [bnss_pkg::POS_W-1:0]  start_position;
	logic [bnss_pkg::RANK_W-1:0] rank;

	modport source (output valid, action, word_select, word_value, start_position, rank,
		input ready);
	modport sink (input valid, action, word_select, word_value, start_position, rank,
		output ready);
endinterface

[hw/rtl/bnss_rsp_if.sv]
// ----------------------------------------------------------------------------
// bnss_rsp_if
// Response channel: position of the selected set bit and the miss flag.
// ----------------------------------------------------------------------------
interface bnss_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [bnss_pkg::POS_W-1:0] found_position;
	logic                       not_found;

	modport source (output valid, found_position, not_found, input ready);
	modport sink (input valid, found_position, not_found, output ready);
endinterface

[hw/rtl/bnss_cfg_if.sv]
// ----------------------------------------------------------------------------
// bnss_cfg_if
// Configuration write channel for the words_in_use register.
// ----------------------------------------------------------------------------
interface bnss_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bnss_pkg::CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[hw/rtl/bnss_store.sv]
// ----------------------------------------------------------------------------
// bnss_store
// Bitmap word memory with one write and one registered read port. Entries
// that have not been written since reset read as zero through valid bits.
// ----------------------------------------------------------------------------
module bnss_store #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bnss_pkg::store_wr_t          wr,
	input  logic [bnss_pkg::WIDX_W-1:0]  rd_addr,
	output bnss_pkg::word_t              rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bnss_pkg::word_t   mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	bnss_pkg::word_t   rdata_s1;
	logic              hit_s1;
	logic              wr_in_range;
	logic              rd_in_range;
	logic [AW-1:0]     wr_idx;
	logic [AW-1:0]     rd_idx;

	assign wr_in_range = 32'(wr.addr) < DEPTH;
	assign rd_in_range = 32'(rd_addr) < DEPTH;
	assign wr_idx      = wr.addr[AW-1:0];
	assign rd_idx      = rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			mem[wr_idx] <= wr.data;
		end
		rdata_s1 <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_s1  <= 1'b0;
		end else begin
			if (wr.en && wr_in_range) begin
				valid_q[wr_idx] <= 1'b1;
			end
			hit_s1 <= rd_in_range && valid_q[rd_idx];
		end
	end

	assign rd_data = hit_s1 ? rdata_s1 : '0;

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && wr_in_range |=> valid_q[$past(wr_idx)])
		else $error("written entry not marked valid");

	a_out_of_range_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_in_range |=> rd_data == '0)
		else $error("read beyond the store returned data");

endmodule

[hw/rtl/bitmap_nth_set_bit_select.sv]
// ----------------------------------------------------------------------------
// bitmap_nth_set_bit_select
// Finds the rank-th set bit at or above a start position in a 64-bit-word
// bitmap.
// ----------------------------------------------------------------------------
// Requests arrive on req. A write request (action 0) stores word_value in
// word word_select and gives no response; words beyond the store are
// dropped. A query request (action 1) searches from start_position upward
// and answers on rsp with the position of the rank-th set bit, or with
// min(words_in_use, WORDS)*64 and not_found set when there are too few
// set bits. The cfg channel writes words_in_use; it is always ready.
// A query reads one bitmap word per cycle from the store (registered read),
// masks it and takes its popcount, then picks the bit within the chosen
// word one byte per cycle, stepping over at most words_in_use words and at
// most seven bytes. The result then passes through the done state into the
// output register. Writes are taken one a cycle while the block is idle.
// The block takes a new request whenever it is idle, even while a finished
// response waits in the output register; a query that completes while the
// receiver stalls waits until that register is free. Reset clears the
// bitmap through valid bits at once and sets words_in_use to 16.
// ----------------------------------------------------------------------------
module bitmap_nth_set_bit_select #(
	parameter int WORDS = 16
) (
	input logic         clk,
	input logic         arst_n,
	bnss_req_if.sink    req,
	bnss_rsp_if.source  rsp,
	bnss_cfg_if.sink    cfg
);

	// At most sixteen words can ever be written; words above the store read as zero.
	localparam int DEPTH = (WORDS < 16) ? WORDS : 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEL,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [bnss_pkg::CFG_W-1:0]        words_in_use_q;
	logic [bnss_pkg::WIDX_W-1:0]       wi_q;
	logic [bnss_pkg::WIDX_W-1:0]       n_q;
	logic [bnss_pkg::POS_W-1:0]        limit_q;
	logic [5:0]                        off_q;
	logic                              first_q;
	logic [bnss_pkg::RANK_W-1:0]       rank_q;
	bnss_pkg::word_t                   sel_word_q;
	logic [5:0]                        k_q;
	logic [2:0]                        byte_q;
	logic [bnss_pkg::POS_W-1:0]        res_pos_q;
	logic                              res_nf_q;
	logic                              out_valid_q;
	logic [bnss_pkg::POS_W-1:0]        out_pos_q;
	logic                              out_nf_q;

	bnss_pkg::store_wr_t               st_wr;
	logic [bnss_pkg::WIDX_W-1:0]       st_rd_addr;
	bnss_pkg::word_t                   st_rd_data;

	logic                              req_acc;
	logic [bnss_pkg::WIDX_W-1:0]       n_eff;
	logic [bnss_pkg::POS_W-1:0]        limit_eff;
	bnss_pkg::word_t                   scan_mask;
	bnss_pkg::word_t                   scan_word;
	logic [6:0]                        scan_pc;
	logic                              scan_hit;
	logic [bnss_pkg::WIDX_W:0]         wi_next;
	logic [7:0]                        cur_byte;
	logic [3:0]                        byte_pc;
	logic                              out_free;

	function automatic logic [6:0] pop64(input bnss_pkg::word_t w);
		logic [6:0] cnt;
		cnt = '0;
		for (int i = 0; i < bnss_pkg::WORD_W; i++) begin
			cnt = cnt + 7'(w[i]);
		end
		return cnt;
	endfunction

	function automatic logic [3:0] pop8(input logic [7:0] b);
		logic [3:0] cnt;
		cnt = '0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + 4'(b[i]);
		end
		return cnt;
	endfunction

	// Index of the k-th set bit of a byte; k is below its popcount.
	function automatic logic [2:0] select8(input logic [7:0] b, input logic [5:0] k);
		logic [5:0] left;
		logic [2:0] idx;
		logic       done;
		left = k;
		idx  = '0;
		done = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (b[i] && !done) begin
				if (left == 6'd0) begin
					idx  = 3'(i);
					done = 1'b1;
				end else begin
					left = left - 6'd1;
				end
			end
		end
		return idx;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign st_wr.en   = req_acc && (req.action == bnss_pkg::ACT_WRITE);
	assign st_wr.addr = req.word_select;
	assign st_wr.data = req.word_value;

	// Queries never overlap writes, so the read ahead needs no forwarding.
	assign st_rd_addr = (state_q == ST_SCAN) ? wi_q + 5'd1 : req.start_position[10:6];

	bnss_store #(.DEPTH(DEPTH)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (st_wr),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	assign n_eff     = (32'(words_in_use_q) > WORDS) ? bnss_pkg::WIDX_W'(WORDS)
		: words_in_use_q;
	assign limit_eff = {n_eff, 6'd0};

	assign scan_mask = first_q ? ({bnss_pkg::WORD_W{1'b1}} << off_q)
		: {bnss_pkg::WORD_W{1'b1}};
	assign scan_word = st_rd_data & scan_mask;
	assign scan_pc   = pop64(scan_word);
	assign scan_hit  = rank_q < {3'd0, scan_pc};
	assign wi_next   = {1'b0, wi_q} + 6'd1;

	assign cur_byte = sel_word_q[{byte_q, 3'd0} +: 8];
	assign byte_pc  = pop8(cur_byte);
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			words_in_use_q <= bnss_pkg::WORDS_IN_USE_RESET;
			wi_q           <= '0;
			n_q            <= '0;
			limit_q        <= '0;
			off_q          <= '0;
			first_q        <= 1'b0;
			rank_q         <= '0;
			sel_word_q     <= '0;
			k_q            <= '0;
			byte_q         <= '0;
			res_pos_q      <= '0;
			res_nf_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_pos_q      <= '0;
			out_nf_q       <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				words_in_use_q <= cfg.data;
			end
			// A response loaded this cycle takes the place of the one leaving.
			if (out_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && (req.action == bnss_pkg::ACT_QUERY)) begin
						n_q     <= n_eff;
						limit_q <= limit_eff;
						wi_q    <= req.start_position[10:6];
						off_q   <= req.start_position[5:0];
						first_q <= 1'b1;
						rank_q  <= req.rank;
						if (req.start_position >= limit_eff) begin
							res_pos_q <= limit_eff;
							res_nf_q  <= 1'b1;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					if (scan_hit) begin
						sel_word_q <= scan_word;
						k_q        <= rank_q[5:0];
						byte_q     <= '0;
						state_q    <= ST_SEL;
					end else begin
						rank_q <= rank_q - {3'd0, scan_pc};
						wi_q   <= wi_next[bnss_pkg::WIDX_W-1:0];
						if (wi_next >= {1'b0, n_q}) begin
							res_pos_q <= limit_q;
							res_nf_q  <= 1'b1;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_SEL: begin
					if (k_q < {2'd0, byte_pc}) begin
						res_pos_q <= {wi_q, byte_q, select8(cur_byte, k_q)};
						res_nf_q  <= 1'b0;
						state_q   <= ST_DONE;
					end else begin
						k_q    <= k_q - {2'd0, byte_pc};
						byte_q <= byte_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_pos_q   <= res_pos_q;
						out_nf_q    <= res_nf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.found_position = out_pos_q;
	assign rsp.not_found      = out_nf_q;

	a_scan_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> wi_q < n_q)
		else $error("scan walked past the words in use");

	a_select_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEL |-> sel_word_q != '0)
		else $error("bit selection entered on an empty word");

	a_hit_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !res_nf_q |-> res_pos_q < limit_q)
		else $error("found position lies beyond the searched words");

endmodule

[bench/bnss_answer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bnss_answer_checker
// Watches the request, response and configuration channels of the bitmap
// nth-set-bit selector, keeps its own copy of the bitmap and of words_in_use,
// works out the answer to every accepted query and compares it with the
// responses as they are accepted, in order.
// ----------------------------------------------------------------------------
module bnss_answer_checker #(
	parameter int WORDS = 16
) (
	input  logic clk,
	input  logic arst_n,
	bnss_req_if  req,
	bnss_rsp_if  rsp,
	bnss_cfg_if  cfg,
	output int   errors,
	output int   outstanding,
	output int   writes_seen,
	output int   queries_seen,
	output int   misses_seen
);

	typedef struct packed {
		logic [bnss_pkg::POS_W-1:0] pos;
		logic                       nf;
	} answer_t;

	answer_t                      expected_answers[$];
	bnss_pkg::word_t              bitmap_shadow[WORDS];
	logic [bnss_pkg::CFG_W-1:0]   words_active;
	int                           err_count;
	int                           n_writes;
	int                           n_queries;
	int                           n_misses;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_count++;
	endtask

	// Position of the rank-th set bit at or above start within the words in use.
	function automatic answer_t select_nth(input logic [bnss_pkg::POS_W-1:0] start,
		input logic [bnss_pkg::RANK_W-1:0] rank);
		int unsigned     n;
		int unsigned     limit;
		int unsigned     wi;
		int unsigned     remaining;
		int unsigned     cnt;
		int              b;
		bnss_pkg::word_t mask;
		bnss_pkg::word_t m;
		answer_t         a;
		n = words_active;
		if (n > WORDS) n = WORDS;
		limit = n * 64;
		a.pos = bnss_pkg::POS_W'(limit);
		a.nf = 1'b1;
		remaining = rank;
		if (start < limit) begin
			mask = {bnss_pkg::WORD_W{1'b1}} << start[5:0];
			for (wi = start / 64; wi < n; wi++) begin
				m = bitmap_shadow[wi] & mask;
				cnt = $countones(m);
				if (remaining < cnt) begin
					for (b = 0; b < bnss_pkg::WORD_W; b++) begin
						if (m[b]) begin
							if (remaining == 0) begin
								a.pos = bnss_pkg::POS_W'(wi * 64 + b);
								a.nf = 1'b0;
								return a;
							end
							remaining--;
						end
					end
				end
				remaining -= cnt;
				mask = {bnss_pkg::WORD_W{1'b1}};
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_ans;
		if (!arst_n) begin
			for (int w = 0; w < WORDS; w++) bitmap_shadow[w] = '0;
			words_active = bnss_pkg::WORDS_IN_USE_RESET;
			expected_answers.delete();
			err_count = 0;
			n_writes = 0;
			n_queries = 0;
			n_misses = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_answers.size() == 0) begin
					report_mismatch($sformatf("response pos=%0d nf=%0b with no query waiting",
						rsp.found_position, rsp.not_found));
				end else begin
					exp_ans = expected_answers.pop_front();
					if (rsp.found_position !== exp_ans.pos)
						report_mismatch($sformatf("found_position %0d, expected %0d",
							rsp.found_position, exp_ans.pos));
					if (rsp.not_found !== exp_ans.nf)
						report_mismatch($sformatf("not_found %0b, expected %0b (pos %0d)",
							rsp.not_found, exp_ans.nf, exp_ans.pos));
					if (exp_ans.nf) n_misses++;
				end
			end
			// A query taken at the same edge as a register write still sees the old value.
			if (req.valid && req.ready) begin
				if (req.action == bnss_pkg::ACT_WRITE) begin
					if (req.word_select < WORDS) bitmap_shadow[req.word_select] = req.word_value;
					n_writes++;
				end else begin
					expected_answers.push_back(select_nth(req.start_position, req.rank));
					n_queries++;
				end
			end
			if (cfg.valid && cfg.ready) words_active = cfg.data;
		end
		errors       <= err_count;
		outstanding  <= expected_answers.size();
		writes_seen  <= n_writes;
		queries_seen <= n_queries;
		misses_seen  <= n_misses;
	end

endmodule

[bench/bitmap_nth_set_bit_select_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_nth_set_bit_select_tb
// Drives bitmap word writes and nth-set-bit queries into the selector under
// several words_in_use settings and idling patterns, including a long
// response hold-off; the answer checker beside the block compares results.
// ----------------------------------------------------------------------------
module bitmap_nth_set_bit_select_tb;

	localparam int WORDS          = 16;
	localparam int RANDOM_ITEMS   = 160;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk;
	logic arst_n;

	bnss_req_if req_ch ();
	bnss_rsp_if rsp_ch ();
	bnss_cfg_if cfg_ch ();

	int errors;
	int outstanding;
	int writes_seen;
	int queries_seen;
	int misses_seen;

	int idle_pct;
	int stall_pct;
	int cur_limit;
	int settings_done;
	int quiet_cycles;
	bit hold_off_go;

	bitmap_nth_set_bit_select #(.WORDS(WORDS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	bnss_answer_checker #(.WORDS(WORDS)) u_answer_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.cfg          (cfg_ch),
		.errors       (errors),
		.outstanding  (outstanding),
		.writes_seen  (writes_seen),
		.queries_seen (queries_seen),
		.misses_seen  (misses_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				idle_pct = 47;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 47;
			end
			3: begin
				idle_pct = 7;
				stall_pct = 7;
			end
			default: begin
				idle_pct = 0;
				stall_pct = 0;
			end
		endcase
	endtask

	task automatic send_item(input logic act, input logic [bnss_pkg::SEL_W-1:0] sel,
		input bnss_pkg::word_t val, input logic [bnss_pkg::POS_W-1:0] start,
		input logic [bnss_pkg::RANK_W-1:0] rnk);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= act;
		req_ch.word_select    <= sel;
		req_ch.word_value     <= val;
		req_ch.start_position <= start;
		req_ch.rank           <= rnk;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// The unused fields of each request carry random values so that every bit toggles.
	task automatic write_word(input logic [bnss_pkg::SEL_W-1:0] sel, input bnss_pkg::word_t val);
		send_item(bnss_pkg::ACT_WRITE, sel, val, bnss_pkg::POS_W'($urandom_range(2047)),
			bnss_pkg::RANK_W'($urandom_range(1023)));
	endtask

	task automatic query(input logic [bnss_pkg::POS_W-1:0] start,
		input logic [bnss_pkg::RANK_W-1:0] rnk);
		send_item(bnss_pkg::ACT_QUERY, bnss_pkg::SEL_W'($urandom_range(15)),
			{$urandom, $urandom}, start, rnk);
	endtask

	// The register is only written once the block has drained and gone quiet.
	task automatic set_words_in_use(input logic [bnss_pkg::CFG_W-1:0] v);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_limit = ((v > WORDS) ? WORDS : v) * 64;
		settings_done++;
	endtask

	function automatic bnss_pkg::word_t random_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return bnss_pkg::word_t'(1) << $urandom_range(63);
			3: return (bnss_pkg::word_t'(1) << $urandom_range(63)) |
				(bnss_pkg::word_t'(1) << $urandom_range(63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_query();
		int                          r;
		logic [bnss_pkg::POS_W-1:0]  start;
		logic [bnss_pkg::RANK_W-1:0] rnk;
		r = $urandom_range(99);
		if (r < 70 && cur_limit > 0) start = bnss_pkg::POS_W'($urandom_range(cur_limit - 1));
		else if (r < 85) start = bnss_pkg::POS_W'(cur_limit - 2 + $urandom_range(3));
		else start = bnss_pkg::POS_W'($urandom_range(2047));
		r = $urandom_range(99);
		if (r < 55) rnk = bnss_pkg::RANK_W'($urandom_range(3));
		else if (r < 85) rnk = bnss_pkg::RANK_W'($urandom_range(63));
		else rnk = bnss_pkg::RANK_W'($urandom_range(1023));
		query(start, rnk);
	endtask

	// Response side: random stalls, or one long hold-off when asked for.
	initial begin
		int hold_count;
		bit hold_off_done;
		hold_off_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				hold_off_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] no request or response moved for %0d cycles", $time,
					quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [bnss_pkg::CFG_W-1:0] settings[8];
		int                         p;
		int                         i;
		settings = '{5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd16, 5'd3, 5'd12};
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.action         <= bnss_pkg::ACT_WRITE;
		req_ch.word_select    <= '0;
		req_ch.word_value     <= '0;
		req_ch.start_position <= '0;
		req_ch.rank           <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.data           <= '0;
		hold_off_go           = 1'b0;
		settings_done         = 0;
		cur_limit             = bnss_pkg::WORDS_IN_USE_RESET * 64;
		set_idling(0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty bitmap after reset, then a few sparse and dense words.
		query(11'd0, 10'd0);
		query(11'd1024, 10'd0);
		query(11'd2047, 10'd1023);
		write_word(4'd0, 64'h1);
		write_word(4'd15, 64'h8000_0000_0000_0000);
		write_word(4'd7, '1);
		query(11'd0, 10'd0);
		query(11'd1, 10'd0);
		query(11'd0, 10'd1);
		query(11'd0, 10'd64);
		query(11'd0, 10'd65);
		query(11'd0, 10'd66);
		query(11'd449, 10'd0);
		query(11'd450, 10'd1023);
		query(11'd1023, 10'd0);
		query(11'd1023, 10'd1);
		query(11'd1024, 10'd0);
		query(11'd1025, 10'd0);

		for (p = 0; p < 8; p++) begin
			set_idling(p % 4);
			set_words_in_use(settings[p]);
			query(11'd0, 10'd0);
			query(bnss_pkg::POS_W'(cur_limit - 1), 10'd0);
			query(bnss_pkg::POS_W'(cur_limit), 10'd0);
			query(bnss_pkg::POS_W'(cur_limit + 1), 10'd0);
			// With the register above the store depth, fill the whole bitmap so the
			// highest rank can be found.
			if (settings[p] > WORDS) begin
				for (i = 0; i < WORDS; i++) write_word(bnss_pkg::SEL_W'(i), '1);
				query(11'd0, 10'd1023);
				query(11'd1023, 10'd1);
				query(11'd1024, 10'd0);
			end
			for (i = 0; i < RANDOM_ITEMS; i++) begin
				if (p == 4 && i == 20) hold_off_go = 1'b1;
				if ($urandom_range(99) < 35)
					write_word(bnss_pkg::SEL_W'($urandom_range(15)), random_word());
				else random_query();
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d word writes and %0d queries (%0d answered not found)",
			writes_seen, queries_seen, misses_seen);
		$display("across %0d words_in_use settings, with and without idling on both sides.",
			settings_done);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[bitmap_nth_set_bit_select.f]
hw/rtl/bnss_pkg.sv
hw/rtl/bnss_req_if.sv
hw/rtl/bnss_rsp_if.sv
hw/rtl/bnss_cfg_if.sv
hw/rtl/bnss_store.sv
hw/rtl/bitmap_nth_set_bit_select.sv
bench/bnss_answer_checker.sv
bench/bitmap_nth_set_bit_select_tb.sv
